// ===== sv/itoa_pkg.sv =====
// itoa_pkg: shared types, constants and a helper function for the
// integer_to_ascii_digits block. No dependencies.
package itoa_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);

    // Input kind codes
    localparam logic [KIND_W-1:0] KIND_SDEC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UDEC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HEXL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_HEXU = 2'd3;

    // Divide by ten as multiply by reciprocal: exact for all 32-bit operands
    localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int unsigned        RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;

    typedef struct packed {
        logic load;      // latch a new operand
        logic step;      // produce one digit, least significant first
        logic pop;       // advance read pointer toward the first digit
        logic sel_sign;  // present '-' on the text channel
    } itoa_cmd_t;

    typedef struct packed {
        logic div_done;  // the current step yields the last digit
        logic negative;  // operand carries a minus sign
        logic rd_zero;   // read pointer is on the final character
    } itoa_sts_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CH_UPPER : CH_LOWER;
        if (d < 4'd10)
            return CH_ZERO + CHAR_W'(d);
        else
            return base + CHAR_W'(d - 4'd10);
    endfunction

endpackage

// ===== sv/itoa_ifs.sv =====
// Handshake channel interfaces for integer_to_ascii_digits: operand
// channel and text channel. Depends on itoa_pkg.
interface itoa_num_if;
    logic                             valid;
    logic                             ready;
    logic [itoa_pkg::KIND_W-1:0]      kind;
    logic [itoa_pkg::VALUE_W-1:0]     value;

    modport source (output valid, kind, value, input ready);
    modport sink   (input valid, kind, value, output ready);
endinterface

interface itoa_txt_if;
    logic                             valid;
    logic                             ready;
    logic [itoa_pkg::CHAR_W-1:0]      text_byte;
    logic                             last;

    modport source (output valid, text_byte, last, input ready);
    modport sink   (input valid, text_byte, last, output ready);
endinterface

// ===== sv/integer_to_ascii_digits.sv =====
// integer_to_ascii_digits: turns one 32-bit operand into ASCII text, one
// character per beat, most significant first, with the final beat flagged.
// Kinds: signed decimal, unsigned decimal, lower-case hex, upper-case hex.
// A negative operand in signed mode gives a leading '-' beat and then its
// magnitude (0x80000000 gives -2147483648); zero gives a single '0'; leading
// zeros are never sent. Timing: the operand is taken, then one digit is
// formed per cycle of division (N digits, at most 10 decimal or 8 hex),
// then one beat per character (N, plus one for the sign) as fast as the
// sink takes them. The digit loop is a single shared divide-by-radix unit
// (a 32x32 reciprocal multiply for decimal, a nibble shift for hex)
// writing a small digit buffer, which is then read back in reverse. The
// operand channel is ready only between items.
// Depends on itoa_pkg, itoa_ifs, itoa_ctrl and itoa_dp.
module integer_to_ascii_digits (
    input  logic       clk,
    input  logic       rst_n,
    itoa_num_if.sink   number,
    itoa_txt_if.source text
);
    import itoa_pkg::*;

    itoa_cmd_t cmd;
    itoa_sts_t sts;

    // sequencer: accept, divide loop, optional sign, digit readout
    itoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (number.valid),
        .in_ready  (number.ready),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // operand, divider and digit buffer
    itoa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .kind      (number.kind),
        .value     (number.value),
        .text_byte (text.text_byte),
        .last      (text.last)
    );

endmodule

// ===== sv/itoa_ctrl.sv =====
// itoa_ctrl: sequencing state machine for integer_to_ascii_digits.
// Depends on itoa_pkg; drives commands to itoa_dp.
module itoa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  itoa_pkg::itoa_sts_t sts,
    output itoa_pkg::itoa_cmd_t cmd
);
    import itoa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_beat;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SIGN) || (state_reg == ST_EMIT);
    assign out_beat  = out_valid && out_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = in_valid && in_ready;
        cmd.step     = (state_reg == ST_DIV);
        cmd.sel_sign = (state_reg == ST_SIGN);
        cmd.pop      = (state_reg == ST_EMIT) && out_beat && !sts.rd_zero;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = sts.negative ? ST_SIGN : ST_EMIT;
            end
            ST_SIGN:
            begin
                if (out_beat)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_beat && sts.rd_zero)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/itoa_dp.sv =====
// itoa_dp: operand register, divide-by-radix step and digit buffer for
// integer_to_ascii_digits. Depends on itoa_pkg; commanded by itoa_ctrl.
module itoa_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  itoa_pkg::itoa_cmd_t          cmd,
    output itoa_pkg::itoa_sts_t          sts,
    input  logic [itoa_pkg::KIND_W-1:0]  kind,
    input  logic [itoa_pkg::VALUE_W-1:0] value,
    output logic [itoa_pkg::CHAR_W-1:0]  text_byte,
    output logic                         last
);
    import itoa_pkg::*;

    logic [VALUE_W-1:0]   mag_reg;
    logic                 neg_reg;
    logic                 hex_reg;
    logic                 upper_reg;
    logic [DIG_IDX_W-1:0] wr_ptr_reg;
    logic [DIG_IDX_W-1:0] rd_ptr_reg;
    logic [CHAR_W-1:0]    digit_buf [MAX_DIGITS];

    logic                   load_neg;
    logic [2*VALUE_W-1:0]   prod;
    logic [VALUE_W-1:0]     quot;
    logic [VALUE_W-1:0]     quot_x10;
    logic [VALUE_W-1:0]     rem_full;
    logic [3:0]             rem;

    assign load_neg = (kind == KIND_SDEC) && value[VALUE_W-1];

    // one multiply for /10; hex is a plain nibble shift
    assign prod     = (2*VALUE_W)'(mag_reg) * (2*VALUE_W)'(RECIP10);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem_full = mag_reg - quot_x10;

    always_comb
    begin
        if (hex_reg)
        begin
            quot = mag_reg >> 4;
            rem  = mag_reg[3:0];
        end
        else
        begin
            quot = VALUE_W'(prod >> RECIP_SHIFT);
            rem  = rem_full[3:0];
        end
    end

    assign sts.div_done = (quot == '0) || (wr_ptr_reg == DIG_IDX_W'(MAX_DIGITS - 1));
    assign sts.negative = neg_reg;
    assign sts.rd_zero  = (rd_ptr_reg == '0);

    assign text_byte = cmd.sel_sign ? CH_MINUS : digit_buf[rd_ptr_reg];
    assign last      = !cmd.sel_sign && (rd_ptr_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg    <= 1'b0;
            mag_reg    <= '0;
            hex_reg    <= 1'b0;
            upper_reg  <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else if (cmd.load)
        begin
            neg_reg    <= load_neg;
            mag_reg    <= load_neg ? (~value + VALUE_W'(1)) : value;
            hex_reg    <= kind[1];
            upper_reg  <= (kind == KIND_HEXU);
            wr_ptr_reg <= '0;
        end
        else if (cmd.step)
        begin
            mag_reg    <= quot;
            wr_ptr_reg <= wr_ptr_reg + DIG_IDX_W'(1);
            rd_ptr_reg <= wr_ptr_reg;
        end
        else if (cmd.pop)
        begin
            rd_ptr_reg <= rd_ptr_reg - DIG_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
            digit_buf[wr_ptr_reg] <= digit_char(rem, upper_reg);
    end

endmodule

// ===== sv/itoa_chk.sv =====
// itoa_chk: port-level checks for integer_to_ascii_digits, attached by bind.
// Depends on itoa_pkg and the top level's ports.
module itoa_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [itoa_pkg::CHAR_W-1:0]  text_byte,
    input logic                         last
);
    import itoa_pkg::*;

    // a finished number frees the operand channel on the next cycle
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> in_ready && !out_valid)
        else $error("operand channel not free after last beat");

    // a number's text has no gaps once it starts
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside a number's text");

    // never a beat in the cycle after an operand is taken
    a_div_first: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("text beat before any digit was formed");

    // a minus sign is never the final character
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (text_byte == CH_MINUS) |-> !last)
        else $error("minus sign flagged as last");

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(text_byte) && $stable(last))
        else $error("stalled beat changed");

endmodule

bind integer_to_ascii_digits itoa_chk u_itoa_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .text_byte (text.text_byte),
    .last      (text.last)
);

// ===== tb/sv/itoa_text_check.sv =====
// itoa_text_check: watches the operand and text channels of
// integer_to_ascii_digits, predicts the character stream and compares it.
// Depends on itoa_pkg and itoa_ifs.
`timescale 1ns / 1ps
module itoa_text_check (
    input  logic        clk,
    input  logic        rst_n,
    itoa_num_if         number,
    itoa_txt_if         text,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    import itoa_pkg::*;

    localparam logic [VALUE_W-1:0] RADIX_DEC   = 10;
    localparam logic [VALUE_W-1:0] RADIX_HEX   = 16;
    localparam int unsigned        REPORT_MAX  = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_beat_t;

    text_beat_t  expected_text[$];
    int unsigned err_cnt = 0;

    // Queue up the characters that one operand turns into, most significant first.
    task automatic predict_text(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [CHAR_W-1:0]  letter_base;
        logic [3:0]         nib [MAX_DIGITS];
        text_beat_t         b;
        int                 n;
        mag         = v;
        radix       = RADIX_DEC;
        n           = 0;
        letter_base = (k == KIND_HEXU) ? CH_UPPER : CH_LOWER;
        if (k == KIND_SDEC && v[VALUE_W-1])
        begin
            mag    = -v;
            b.ch   = CH_MINUS;
            b.last = 1'b0;
            expected_text.push_back(b);
        end
        else if (k == KIND_HEXL || k == KIND_HEXU)
        begin
            radix = RADIX_HEX;
        end
        do
        begin
            nib[n] = 4'(mag % radix);
            n++;
            mag = mag / radix;
        end
        while (mag != 0 && n < MAX_DIGITS);
        for (int i = n - 1; i >= 0; i--)
        begin
            if (nib[i] < 4'd10)
                b.ch = CH_ZERO + CHAR_W'(nib[i]);
            else
                b.ch = letter_base + CHAR_W'(nib[i] - 4'd10);
            b.last = (i == 0);
            expected_text.push_back(b);
        end
    endtask

    task automatic report(input string what, input logic [CHAR_W-1:0] exp_v,
                          input logic [CHAR_W-1:0] act_v);
        if (err_cnt < REPORT_MAX)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
        err_cnt++;
    endtask

    always @(posedge clk)
    begin
        text_beat_t exp_b;
        if (rst_n)
        begin
            if (text.valid && text.ready)
            begin
                if (expected_text.size() == 0)
                begin
                    report("unexpected text beat", '0, text.text_byte);
                end
                else
                begin
                    exp_b = expected_text.pop_front();
                    if (text.text_byte !== exp_b.ch)
                        report("text_byte", exp_b.ch, text.text_byte);
                    if (text.last !== exp_b.last)
                        report("last", CHAR_W'(exp_b.last), CHAR_W'(text.last));
                end
            end
            if (number.valid && number.ready)
                predict_text(number.kind, number.value);
        end
        mismatches  <= err_cnt;
        outstanding <= expected_text.size();
    end

endmodule

// ===== tb/sv/integer_to_ascii_digits_tb.sv =====
// integer_to_ascii_digits_tb: drives operands into integer_to_ascii_digits
// with random gaps and text back-pressure, and gives the verdict.
// Depends on itoa_pkg, itoa_ifs, the block and itoa_text_check.
`timescale 1ns / 1ps
module integer_to_ascii_digits_tb;
    import itoa_pkg::*;

    localparam int unsigned RANDOM_ITEMS    = 188;
    localparam int unsigned MAX_GAP         = 13;
    // one long receiver stall, well after start, so the block backs up
    localparam int unsigned HOLD_OFF_AT     = 60;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned IDLE_LIMIT      = 2000;
    // worst item: 11 beats, each possibly stalled by the receiver
    localparam int unsigned DRAIN_CYCLES    = 200;

    logic        clk;
    logic        rst_n;
    logic        num_burst = 1'b0;
    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned idle_cycles = 0;

    itoa_num_if number_ch();
    itoa_txt_if text_ch();

    integer_to_ascii_digits i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_ch),
        .text   (text_ch)
    );

    itoa_text_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .number      (number_ch),
        .text        (text_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one operand beat after a random gap; returns at the accepting edge.
    // With a zero gap valid simply stays high from the previous beat.
    task automatic send_number(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
        int unsigned gap;
        gap = num_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            number_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        number_ch.valid <= 1'b1;
        number_ch.kind  <= k;
        number_ch.value <= v;
        @(posedge clk);
        while (!number_ch.ready) @(posedge clk);
    endtask

    // Powers of ten and sixteen, one off and negated: digit-count boundaries.
    function automatic logic [VALUE_W-1:0] boundary_value();
        logic [VALUE_W-1:0] p;
        int unsigned        k;
        p = 1;
        if ($urandom_range(0, 1))
        begin
            k = $urandom_range(0, 9);
            repeat (k) p = p * 10;
        end
        else
        begin
            p = p << (4 * $urandom_range(0, 7));
        end
        case ($urandom_range(0, 2))
            0:       return p;
            1:       return p - 1;
            default: return -p;
        endcase
    endfunction

    // Mix of full-width values, short numbers (few digits) and boundaries.
    function automatic logic [VALUE_W-1:0] random_operand();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 4))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 20);
            2:       v = ~VALUE_W'($urandom_range(0, 20));
            3:       v = $urandom >> $urandom_range(0, VALUE_W - 1);
            default: v = boundary_value();
        endcase
        return v;
    endfunction

    // Operand side: directed corners first, then random traffic.
    initial
    begin
        number_ch.valid <= 1'b0;
        number_ch.kind  <= KIND_SDEC;
        number_ch.value <= '0;
        rst_n           <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // signed decimal: zero, small, extremes, most negative, ten digits
        send_number(KIND_SDEC, 32'd0);
        send_number(KIND_SDEC, 32'd9);
        send_number(KIND_SDEC, 32'd1);
        send_number(KIND_SDEC, 32'h7FFF_FFFF);
        send_number(KIND_SDEC, 32'h8000_0000);
        send_number(KIND_SDEC, 32'hFFFF_FFFF);
        send_number(KIND_SDEC, 32'hFFFF_FFF6);
        send_number(KIND_SDEC, 32'd1_000_000_000);
        // unsigned decimal: negative bit patterns read as plain unsigned
        send_number(KIND_UDEC, 32'd0);
        send_number(KIND_UDEC, 32'hFFFF_FFFF);
        send_number(KIND_UDEC, 32'h8000_0000);
        send_number(KIND_UDEC, 32'd10);
        send_number(KIND_UDEC, 32'd4_000_000_000);
        // hex, both letter cases
        send_number(KIND_HEXL, 32'd0);
        send_number(KIND_HEXL, 32'hFFFF_FFFF);
        send_number(KIND_HEXL, 32'hABCD_EF01);
        send_number(KIND_HEXL, 32'h0000_000F);
        send_number(KIND_HEXU, 32'd0);
        send_number(KIND_HEXU, 32'hFFFF_FFFF);
        send_number(KIND_HEXU, 32'hABCD_EF01);
        send_number(KIND_HEXU, 32'h1000_0000);
        send_number(KIND_HEXU, 32'h0123_4567);

        // every third window of 30 beats goes back to back
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            num_burst = ((i / 30) % 3 == 2);
            send_number(KIND_W'($urandom_range(KIND_SDEC, KIND_HEXU)), random_operand());
        end
        number_ch.valid <= 1'b0;

        // outstanding is registered in the checker, so step once before looking
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Text side: random stall before each beat, bursts of no stall,
    // and one long hold-off while operands keep coming.
    initial
    begin
        int unsigned stall;
        int unsigned beats_taken;
        logic        held;
        text_ch.ready <= 1'b0;
        beats_taken   = 0;
        held          = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && beats_taken >= HOLD_OFF_AT)
            begin
                stall = HOLD_OFF_CYCLES;
                held  = 1'b1;
            end
            else if ((beats_taken / 50) % 4 == 3)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, MAX_GAP);
            end
            if (stall > 0)
            begin
                text_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            text_ch.ready <= 1'b1;
            @(posedge clk);
            while (!text_ch.valid) @(posedge clk);
            beats_taken++;
        end
    end

    // Watchdog: any beat on either channel resets the quiet count.
    always @(posedge clk)
    begin
        if ((number_ch.valid && number_ch.ready) || (text_ch.valid && text_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== integer_to_ascii_digits.f =====
sv/itoa_pkg.sv
sv/itoa_ifs.sv
sv/itoa_ctrl.sv
sv/itoa_dp.sv
sv/integer_to_ascii_digits.sv
sv/itoa_chk.sv
tb/sv/itoa_text_check.sv
tb/sv/integer_to_ascii_digits_tb.sv
